// ----- src/pbp_pkg.sv -----
// Shared types and codes for the perceptron branch predictor.
package pbp_pkg;

	localparam int OP_W         = 2;
	localparam int THREAD_W     = 2;
	localparam int ADDR_W       = 48;
	localparam int HIST_IO_W    = 16;
	localparam int INDEX_IO_W   = 10;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 12;
	localparam int SHIFT_W      = 3;
	localparam int THRESH_W     = 12;

	localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESOLVE = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] CFG_ADDR_SHIFT      = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TRAIN_THRESHOLD = 1'd1;

	localparam logic [SHIFT_W-1:0]  ADDR_SHIFT_RST = 3'd2;
	localparam logic [THRESH_W-1:0] THRESH_RST     = 12'd0;

	typedef struct packed {
		logic [OP_W-1:0]       op;
		logic [THREAD_W-1:0]   thread;
		logic [ADDR_W-1:0]     pc;
		logic                  taken;
		logic                  squashed;
		logic [HIST_IO_W-1:0]  saved_history;
		logic [INDEX_IO_W-1:0] saved_index;
	} cmd_t;

	typedef struct packed {
		logic                  predict_taken;
		logic [HIST_IO_W-1:0]  history_snapshot;
		logic [INDEX_IO_W-1:0] row_index;
	} result_t;

endpackage

// ----- src/perceptron_branch_predictor.sv -----
// Perceptron branch predictor: weight memory, per-thread history, sum and training.
//
//  channel   signals                       handshake
//  -------   ---------------------------   -----------------------------------
//  command   start, busy, cmd              taken at edge with start && !busy
//  result    result_strobe, result         one cycle, no back-pressure
//  config    cfg_we, cfg_index, cfg_data   written at edge with cfg_we high
//
// A lookup or an unsquashed resolve reads its weight row from the single-port memory
// at the accept edge, forms partial sums in S_RD, and in S_FIN forms the final sum
// and decision and, for a resolve that trains, writes the row back. The lookup result
// is strobed in S_FIN. A push, a squash or an unused op leaves the block idle.
// After reset a clearing pass zeroes every row of the weight memory,
// busy stays high meanwhile; config writes are taken throughout.
module perceptron_branch_predictor #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int HISTORY_LEN   = 16,
	parameter int WEIGHT_BITS   = 8,
	parameter int THREADS       = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  pbp_pkg::cmd_t                       cmd,
	output logic                                result_strobe,
	output pbp_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [pbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [pbp_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// TABLE_ENTRIES must be a power of two, the block does not enforce it: rows are indexed by plain masking
	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int TID_W  = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int COLS   = HISTORY_LEN + 1;
	localparam int ROW_W  = COLS * WEIGHT_BITS;
	localparam int GRP    = 4;
	localparam int NGRP   = (COLS + GRP - 1) / GRP;
	localparam int SUM_W  = WEIGHT_BITS + $clog2(COLS + 1) + 1;
	localparam int CMP_W  = (SUM_W > pbp_pkg::THRESH_W + 1) ? SUM_W : pbp_pkg::THRESH_W + 1;
	localparam logic signed [WEIGHT_BITS-1:0] MAX_W =
		WEIGHT_BITS'((1 << (WEIGHT_BITS - 1)) - 1);
	localparam logic signed [WEIGHT_BITS-1:0] ONE_W = WEIGHT_BITS'(1);
	localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q, state_d;

	logic [pbp_pkg::SHIFT_W-1:0]  addr_shift_q;
	logic [pbp_pkg::THRESH_W-1:0] thresh_q;

	logic [HISTORY_LEN-1:0] hist_q [THREADS];

	logic             clearing_q;
	logic [IDX_W-1:0] clr_addr_q;

	logic [ROW_W-1:0] mem [TABLE_ENTRIES];
	logic [ROW_W-1:0] rd_data_s1;
	logic             mem_re, mem_we;
	logic [IDX_W-1:0] mem_ra, mem_wa;
	logic [ROW_W-1:0] mem_wd;

	logic [pbp_pkg::OP_W-1:0] op_s1;
	logic [IDX_W-1:0]         row_s1;
	logic [HISTORY_LEN-1:0]   hist_s1;
	logic                     taken_s1;

	logic signed [SUM_W-1:0] grp_d  [NGRP];
	logic signed [SUM_W-1:0] grp_s2 [NGRP];
	logic signed [SUM_W-1:0] sum;
	logic        [CMP_W-1:0] mag;
	logic                    pred, train;
	logic [ROW_W-1:0]        new_row;

	logic                   accept;
	logic [TID_W-1:0]       tid;
	logic [IDX_W-1:0]       lookup_row, saved_row;
	logic [HISTORY_LEN-1:0] saved_hist;
	logic [pbp_pkg::ADDR_W-1:0]             addr_sh;
	logic [IDX_W+pbp_pkg::INDEX_IO_W-1:0]   sidx_ext, ridx_ext;
	logic [HISTORY_LEN+pbp_pkg::HIST_IO_W-1:0] shist_ext, snap_ext;

	// thread number is below four, so at most three subtractions
	function automatic logic [TID_W-1:0] tid_of(input logic [pbp_pkg::THREAD_W-1:0] t);
		logic [3:0] v;
		v = 4'(t);
		for (int i = 0; i < 3; i++) begin
			if (v >= 4'(THREADS)) v = v - 4'(THREADS);
		end
		return TID_W'(v);
	endfunction

	assign accept = start && !busy;
	assign busy   = clearing_q || (state_q != S_IDLE);

	always_comb begin
		tid        = tid_of(cmd.thread);
		addr_sh    = cmd.pc >> addr_shift_q;
		lookup_row = addr_sh[IDX_W-1:0];
		sidx_ext   = (IDX_W + pbp_pkg::INDEX_IO_W)'(cmd.saved_index);
		saved_row  = sidx_ext[IDX_W-1:0];
		shist_ext  = (HISTORY_LEN + pbp_pkg::HIST_IO_W)'(cmd.saved_history);
		saved_hist = shist_ext[HISTORY_LEN-1:0];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_shift_q <= pbp_pkg::ADDR_SHIFT_RST;
			thresh_q     <= pbp_pkg::THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pbp_pkg::CFG_ADDR_SHIFT:      addr_shift_q <= cfg_data[pbp_pkg::SHIFT_W-1:0];
				pbp_pkg::CFG_TRAIN_THRESHOLD: thresh_q     <= cfg_data[pbp_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// per-thread history: push and squash act at the accept edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < THREADS; t++) hist_q[t] <= '0;
		end else if (accept) begin
			if (cmd.op == pbp_pkg::OP_PUSH) begin
				hist_q[tid] <= HISTORY_LEN'({hist_q[tid], cmd.taken});
			end else if (cmd.op == pbp_pkg::OP_RESOLVE && cmd.squashed) begin
				hist_q[tid] <= saved_hist;
			end
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (clr_addr_q == LAST_ROW) clearing_q <= 1'b0;
		end
	end

	// weight memory, single port: a read and a write never fall in one cycle
	assign mem_re = accept && ((cmd.op == pbp_pkg::OP_LOOKUP) ||
		(cmd.op == pbp_pkg::OP_RESOLVE && !cmd.squashed));
	assign mem_ra = (cmd.op == pbp_pkg::OP_LOOKUP) ? lookup_row : saved_row;
	assign mem_we = clearing_q ||
		(state_q == S_FIN && op_s1 == pbp_pkg::OP_RESOLVE && train);
	assign mem_wa = clearing_q ? clr_addr_q : row_s1;
	assign mem_wd = clearing_q ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_data_s1 <= mem[mem_ra];
	end

	// item context held for the whole operation
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= cmd.op;
			taken_s1 <= cmd.taken;
			if (cmd.op == pbp_pkg::OP_LOOKUP) begin
				row_s1  <= lookup_row;
				hist_s1 <= hist_q[tid];
			end else begin
				row_s1  <= saved_row;
				hist_s1 <= saved_hist;
			end
		end
	end

	// partial sums over groups of four weights
	always_comb begin
		logic signed [WEIGHT_BITS-1:0] w;
		logic signed [SUM_W-1:0]       e;
		int j;
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				j = g * GRP + k;
				if (j < COLS) begin
					w = rd_data_s1[j*WEIGHT_BITS +: WEIGHT_BITS];
					e = SUM_W'(w);
					if (j == 0) grp_d[g] = grp_d[g] + e;
					else if (hist_s1[j-1]) grp_d[g] = grp_d[g] + e;
					else grp_d[g] = grp_d[g] - e;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			for (int g = 0; g < NGRP; g++) grp_s2[g] <= grp_d[g];
		end
	end

	// final sum, decision and trained row
	always_comb begin
		logic signed [SUM_W-1:0]       neg;
		logic signed [WEIGHT_BITS-1:0] w;
		logic                          up;
		sum = '0;
		for (int g = 0; g < NGRP; g++) sum = sum + grp_s2[g];
		pred  = !sum[SUM_W-1];
		neg   = -sum;
		mag   = pred ? CMP_W'(unsigned'(sum)) : CMP_W'(unsigned'(neg));
		train = (pred != taken_s1) || (mag <= CMP_W'(thresh_q));
		for (int j = 0; j < COLS; j++) begin
			w  = rd_data_s1[j*WEIGHT_BITS +: WEIGHT_BITS];
			up = (j == 0) ? taken_s1 : (hist_s1[(j == 0) ? 0 : j-1] == taken_s1);
			if (up) new_row[j*WEIGHT_BITS +: WEIGHT_BITS] = (w == MAX_W) ? w : w + ONE_W;
			else    new_row[j*WEIGHT_BITS +: WEIGHT_BITS] = (w == -MAX_W) ? w : w - ONE_W;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (mem_re) state_d = S_RD;
			S_RD:   state_d = S_FIN;
			S_FIN:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		ridx_ext = (IDX_W + pbp_pkg::INDEX_IO_W)'(row_s1);
		snap_ext = (HISTORY_LEN + pbp_pkg::HIST_IO_W)'(hist_s1);
		result_strobe           = (state_q == S_FIN) && (op_s1 == pbp_pkg::OP_LOOKUP);
		result.predict_taken    = pred;
		result.history_snapshot = snap_ext[pbp_pkg::HIST_IO_W-1:0];
		result.row_index        = ridx_ext[pbp_pkg::INDEX_IO_W-1:0];
	end

	a_lookup_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.op == pbp_pkg::OP_LOOKUP) |=> ##1 result_strobe)
		else $error("lookup gave no result two cycles after accept");

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_re && mem_we))
		else $error("weight memory read and write in one cycle");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (busy && state_q == S_IDLE))
		else $error("item in flight during clearing pass");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (busy && $past(state_q) == S_RD))
		else $error("result strobe outside final cycle of a lookup");

endmodule
